FILE: hdl/ftws_pkg.sv
// ----------------------------------------------------------------------------
// ftws_pkg: shared types and constants for the frame time window statistics
// Scale constants for the rate meter and the divider request/response bundles.
// ----------------------------------------------------------------------------
package ftws_pkg;

  localparam int FT_W      = 32;   // frame time width
  localparam int TS_W      = 64;   // timestamp width
  localparam int PERIOD_W  = 34;   // sampling period register width
  localparam int RATE_W    = 32;   // milli-fps width
  localparam int CNT_W     = 32;   // frames since last update
  localparam int SLOT_OUT_W = 10;  // reported slot index width

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(500000000);

  // 10^12 = 0xE8_D4A51000, split into a 32-bit low part and an 8-bit high part
  localparam int SCALE_HI_W = 8;
  localparam logic [31:0]           SCALE_LO = 32'hD4A5_1000;
  localparam logic [SCALE_HI_W-1:0] SCALE_HI = 8'hE8;

  // numerator is frames * 10^12, below 2^72
  localparam int NUM_W    = CNT_W + 32 + SCALE_HI_W;
  localparam int STEP_W   = $clog2(NUM_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] frames;
    logic [TS_W-1:0]  elapsed;
  } ftws_div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [RATE_W-1:0] rate;
  } ftws_div_rsp_t;

endpackage

FILE: hdl/ftws_rate_div.sv
// ----------------------------------------------------------------------------
// ftws_rate_div: milli-fps rate unit
// floor(10^12 * frames / elapsed), saturated to 32 bits, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ftws_rate_div
  import ftws_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  ftws_div_req_t div_req,
  output ftws_div_rsp_t div_rsp
);

  typedef enum logic [4:0] {
    D_IDLE = 5'b00001,
    D_MUL  = 5'b00010,
    D_SUM  = 5'b00100,
    D_DIV  = 5'b01000,
    D_DONE = 5'b10000
  } div_state_t;

  div_state_t state_r, state_nxt;

  logic [CNT_W-1:0]             n_r;
  logic [TS_W-1:0]              d_r;
  logic [63:0]                  p0_r;
  logic [CNT_W+SCALE_HI_W-1:0]  p1_r;
  logic [NUM_W-1:0]             num_r;
  logic [TS_W-1:0]              rem_r;
  logic [RATE_W-1:0]            q_r;
  logic                         sat_r;
  logic [STEP_W-1:0]            step_r;

  logic [TS_W:0] trial;
  logic [TS_W:0] diff;
  logic          ge;

  // one restoring step
  assign trial = {rem_r, num_r[NUM_W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = (trial >= {1'b0, d_r});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      D_IDLE: begin
        if (div_req.start) begin
          state_nxt = (div_req.elapsed == '0) ? D_DONE : D_MUL;
        end
      end
      D_MUL:  state_nxt = D_SUM;
      D_SUM:  state_nxt = D_DIV;
      D_DIV: begin
        if (step_r == '0) begin
          state_nxt = D_DONE;
        end
      end
      D_DONE: state_nxt = D_IDLE;
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      D_IDLE: begin
        if (div_req.start) begin
          n_r   <= div_req.frames;
          d_r   <= div_req.elapsed;
          q_r   <= '0;
          rem_r <= '0;
          // zero elapsed time: full scale if any frame was counted
          sat_r <= (div_req.elapsed == '0) && (div_req.frames != '0);
        end
      end
      D_MUL: begin
        p0_r <= n_r * SCALE_LO;
        p1_r <= n_r * SCALE_HI;
      end
      D_SUM: begin
        num_r  <= NUM_W'(p0_r) + {p1_r, 32'b0};
        step_r <= LAST_STEP;
      end
      D_DIV: begin
        rem_r  <= ge ? diff[TS_W-1:0] : trial[TS_W-1:0];
        num_r  <= {num_r[NUM_W-2:0], 1'b0};
        q_r    <= {q_r[RATE_W-2:0], ge};
        // a bit pushed past the top means a quotient of 2^32 or more
        sat_r  <= sat_r | q_r[RATE_W-1];
        step_r <= step_r - 1'b1;
      end
      D_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign div_rsp.busy = (state_r != D_IDLE);
  assign div_rsp.done = (state_r == D_DONE);
  assign div_rsp.rate = sat_r ? '1 : q_r;

endmodule

FILE: hdl/frame_time_window_stats.sv
// ----------------------------------------------------------------------------
// frame_time_window_stats: sliding window min/max of frame times and rate meter
// An input transfer starts the window scan (one memory read a cycle, a last
//   fold, a hand-off) and, on a closed period, the bit-serial rate divider
//   (multiply, sum, 72 quotient steps, done); out_valid comes once both finish.
//   A new frame is taken only after the previous result moves to the output
//   register, which waits while out_stall keeps that register full.
// Reset: synchronous active-low; no clearing pass, unwritten slots read zero.
// ----------------------------------------------------------------------------
module frame_time_window_stats
  import ftws_pkg::*;
#(
  parameter int WINDOW = 200
) (
  input  logic                  clk,
  input  logic                  rst_n,

  // frame input
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [TS_W-1:0]       in_now_ns,
  input  logic [FT_W-1:0]       in_frame_time_ns,

  // result output
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [FT_W-1:0]       out_min_frame_ns,
  output logic [FT_W-1:0]       out_max_frame_ns,
  output logic [RATE_W-1:0]     out_fps_milli,
  output logic                  out_fps_updated,
  output logic [SLOT_OUT_W-1:0] out_slot_written,

  // sampling period register
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [PERIOD_W-1:0]   cfg_sampling_period_ns
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  // IDLE takes a frame, SCAN streams the window through the min/max fold, WAIT
  // folds the last read, DONE hands off once rate unit and output slot are free.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [PERIOD_W-1:0] period_r;

  // persistent meter state
  logic [TS_W-1:0]   frame_count_r;
  logic [CNT_W-1:0]  fsu_r;           // frames since last rate update
  logic [TS_W-1:0]   last_update_r;
  logic [RATE_W-1:0] fps_r;
  logic [SLOT_W-1:0] slot_r;          // next slot to write
  logic              full_r;          // every slot written at least once

  // per-item working registers
  logic [SLOT_W-1:0] cur_slot_r;
  logic              upd_r;
  logic [SLOT_W-1:0] rd_addr_r;
  logic              rd_vld_r;
  logic              rd_ok_r;
  logic [FT_W-1:0]   rdata_r;
  logic [FT_W-1:0]   min_r;
  logic [FT_W-1:0]   max_r;

  // output register
  logic                  out_valid_r;
  logic [FT_W-1:0]       out_min_r;
  logic [FT_W-1:0]       out_max_r;
  logic [RATE_W-1:0]     out_fps_r;
  logic                  out_upd_r;
  logic [SLOT_OUT_W-1:0] out_slot_r;

  // window store, no reset: slots past the fill point are masked to zero
  logic [FT_W-1:0] win_mem [WINDOW];

  logic          in_xfer;
  logic          out_load;
  logic [TS_W-1:0] elapsed;
  logic          fire;
  logic [FT_W-1:0] fold_val;
  logic [SLOT_W-1:0] slot_nxt;

  ftws_div_req_t div_req;
  ftws_div_rsp_t div_rsp;

  // --------------------------------------------------------------------------
  // handshakes
  // --------------------------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // result leaves DONE once the rate unit is idle and the output slot is free
  assign out_load = (state_r == ST_DONE) && !div_rsp.busy && (!out_valid_r || !out_stall);

  // --------------------------------------------------------------------------
  // rate check: wrapping elapsed time against the sampling period
  // --------------------------------------------------------------------------
  assign elapsed = in_now_ns - last_update_r;
  assign fire    = (elapsed >= TS_W'(period_r));

  assign div_req.start   = in_xfer && fire;
  assign div_req.frames  = fsu_r;
  assign div_req.elapsed = elapsed;

  ftws_rate_div u_rate_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  // ring pointer; the 64-bit frame count wrapping restarts the ring at slot 0
  always_comb begin
    priority if (frame_count_r == '1) begin
      slot_nxt = '0;
    end else if (slot_r == LAST_SLOT) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_addr_r == LAST_SLOT) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // control and meter state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      period_r      <= PERIOD_RESET;
      frame_count_r <= '0;
      fsu_r         <= '0;
      last_update_r <= '0;
      fps_r         <= '0;
      slot_r        <= '0;
      full_r        <= 1'b0;
      rd_vld_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == ST_SCAN);

      if (cfg_valid && cfg_ready) begin
        period_r <= cfg_sampling_period_ns;
      end

      if (in_xfer) begin
        frame_count_r <= frame_count_r + 1'b1;
        slot_r        <= slot_nxt;
        full_r        <= full_r || (slot_r == LAST_SLOT);
        // a closed period restarts the count at this frame
        if (fire) begin
          fsu_r         <= CNT_W'(1);
          last_update_r <= in_now_ns;
        end else if (fsu_r != '1) begin
          fsu_r <= fsu_r + 1'b1;
        end
      end

      if (div_rsp.done) begin
        fps_r <= div_rsp.rate;
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // window memory: write on frame transfer, scan reads start the next cycle,
  // so a read never overlaps the write of the same item
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      win_mem[slot_r] <= in_frame_time_ns;
    end
    if (state_r == ST_SCAN) begin
      rdata_r <= win_mem[rd_addr_r];
      rd_ok_r <= full_r || (rd_addr_r <= cur_slot_r);
    end
  end

  // --------------------------------------------------------------------------
  // scan address and min/max fold
  // --------------------------------------------------------------------------
  assign fold_val = rd_ok_r ? rdata_r : '0;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cur_slot_r <= slot_r;
      upd_r      <= fire;
      rd_addr_r  <= '0;
      min_r      <= '1;
      max_r      <= '0;
    end else begin
      if (state_r == ST_SCAN) begin
        rd_addr_r <= rd_addr_r + 1'b1;
      end
      if (rd_vld_r) begin
        if (fold_val < min_r) begin
          min_r <= fold_val;
        end
        if (fold_val > max_r) begin
          max_r <= fold_val;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_min_r  <= min_r;
      out_max_r  <= max_r;
      out_fps_r  <= fps_r;
      out_upd_r  <= upd_r;
      out_slot_r <= SLOT_OUT_W'(cur_slot_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_min_frame_ns = out_min_r;
  assign out_max_frame_ns = out_max_r;
  assign out_fps_milli    = out_fps_r;
  assign out_fps_updated  = out_upd_r;
  assign out_slot_written = out_slot_r;

endmodule

FILE: hdl/ftws_checker.sv
// ----------------------------------------------------------------------------
// ftws_checker: port-level checks for frame_time_window_stats
// Watches the frame and result channels over time.
// ----------------------------------------------------------------------------
module ftws_checker #(
  parameter int WINDOW = 200
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_min_frame_ns,
  input logic [31:0] out_max_frame_ns,
  input logic [31:0] out_fps_milli,
  input logic [9:0]  out_slot_written
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_min_frame_ns)
      && $stable(out_max_frame_ns) && $stable(out_fps_milli))
    else $error("result changed while stalled");

  // one frame in flight: input stalls right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after transfer");

  // window statistics are ordered
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_min_frame_ns <= out_max_frame_ns)
    else $error("min above max");

  // reported slot lies in the ring; one spare bit so a 1024-slot ring fits
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_slot_written} < 11'(WINDOW))
    else $error("slot outside window");

endmodule

bind frame_time_window_stats ftws_checker #(.WINDOW(WINDOW)) u_ftws_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_min_frame_ns (out_min_frame_ns),
  .out_max_frame_ns (out_max_frame_ns),
  .out_fps_milli    (out_fps_milli),
  .out_slot_written (out_slot_written)
);

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: frame time window statistics, self-checking
// Streams frames (timestamp and frame time) into the block and checks every
// result (window min/max, milli-fps, update flag, slot) against an in-bench
// predictor. Directed corner frames are followed by random phases at several
// sampling periods and idle/stall mixes, plus one long result hold-off.
// ----------------------------------------------------------------------------
module testbench
  import ftws_pkg::*;
;

  localparam int SLOTS = 200;
  localparam logic [127:0] MILLI_SCALE = 128'd1_000_000_000_000;
  localparam int PRINT_CAP = 200;

  typedef struct packed {
    logic [TS_W-1:0] now_ns;
    logic [FT_W-1:0] frame_ns;
  } frame_rec_t;

  typedef struct packed {
    logic [FT_W-1:0]       min_ns;
    logic [FT_W-1:0]       max_ns;
    logic [RATE_W-1:0]     fps;
    logic                  updated;
    logic [SLOT_OUT_W-1:0] slot;
  } window_stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TS_W-1:0]       in_now_ns = '0;
  logic [FT_W-1:0]       in_frame_time_ns = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FT_W-1:0]       out_min_frame_ns;
  logic [FT_W-1:0]       out_max_frame_ns;
  logic [RATE_W-1:0]     out_fps_milli;
  logic                  out_fps_updated;
  logic [SLOT_OUT_W-1:0] out_slot_written;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [PERIOD_W-1:0]   cfg_sampling_period_ns = '0;

  frame_rec_t    frame_q[$];   // frames waiting to be offered
  window_stats_t stats_q[$];   // predicted results, oldest first

  // predictor state, mirrors the block's registers
  logic [FT_W-1:0]     ring_ns [SLOTS];
  logic [63:0]         frames_total = '0;
  logic [CNT_W-1:0]    since_rate = '0;
  logic [TS_W-1:0]     last_rate_ns = '0;
  logic [RATE_W-1:0]   fps_now = '0;
  logic [PERIOD_W-1:0] period_ns = PERIOD_RESET;

  // traffic shaping knobs, percentages per cycle
  int  send_idle_pct = 0;
  int  stall_pct = 0;
  int  hold_left = 0;      // long result hold-off, counted down by the stall process
  logic in_taken = 1'b0;   // input transfer happened at the last rising edge
  int  mismatches = 0;

  logic [TS_W-1:0] stamp_ns;

  frame_time_window_stats #(.WINDOW(SLOTS)) u_top (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_now_ns              (in_now_ns),
    .in_frame_time_ns       (in_frame_time_ns),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_min_frame_ns       (out_min_frame_ns),
    .out_max_frame_ns       (out_max_frame_ns),
    .out_fps_milli          (out_fps_milli),
    .out_fps_updated        (out_fps_updated),
    .out_slot_written       (out_slot_written),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_sampling_period_ns (cfg_sampling_period_ns)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Safety net: well above the slowest legal run (about 1200 frames, each
  // through the full window scan, plus worst idle/stall tails and the hold-off).
  initial begin
    #30_000_000;
    $display("frame_time_window_stats verification failed");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // floor(1e12 * frames / span), clipped to 32 bits; zero span means the
  // period is 0 and the rate pins to full scale unless no frame was counted
  function automatic logic [RATE_W-1:0] milli_fps(input logic [CNT_W-1:0] frames,
                                                   input logic [TS_W-1:0] span);
    logic [127:0] quo;
    if (span == '0) begin
      return (frames != '0) ? '1 : '0;
    end
    quo = (128'(frames) * MILLI_SCALE) / 128'(span);
    return (quo > 128'hFFFF_FFFF) ? '1 : quo[RATE_W-1:0];
  endfunction

  // one frame through the window and rate meter
  function automatic window_stats_t predict_stats(input logic [TS_W-1:0] now,
                                                  input logic [FT_W-1:0] frame);
    window_stats_t r;
    logic [TS_W-1:0] span;
    int unsigned idx;
    int k;
    idx = int'(frames_total % 64'(SLOTS));
    ring_ns[idx] = frame;
    span = now - last_rate_ns;   // wraps, so a backward stamp forces an update
    r.updated = 1'b0;
    if (span >= TS_W'(period_ns)) begin
      fps_now = milli_fps(since_rate, span);
      since_rate = '0;
      last_rate_ns = now;
      r.updated = 1'b1;
    end
    r.min_ns = ring_ns[0];
    r.max_ns = ring_ns[0];
    for (k = 1; k < SLOTS; k++) begin
      if (ring_ns[k] < r.min_ns) r.min_ns = ring_ns[k];
      if (ring_ns[k] > r.max_ns) r.max_ns = ring_ns[k];
    end
    frames_total++;
    if (since_rate != '1) since_rate++;
    r.fps = fps_now;
    r.slot = SLOT_OUT_W'(idx);
    return r;
  endfunction

  // Frame driver: a new frame goes up only once the previous one transferred.
  always @(negedge clk) begin : drive_frames
    frame_rec_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (frame_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        nxt = frame_q[0];
        frame_q.delete(0);
        in_valid <= 1'b1;
        in_now_ns <= nxt.now_ns;
        in_frame_time_ns <= nxt.frame_ns;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result back-pressure: random stall, or a forced hold-off while counting down.
  always @(negedge clk) begin : drive_stall
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitor: predict on each input transfer, check each result transfer.
  always @(posedge clk) begin : watch_ports
    window_stats_t want;
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        stats_q.insert(stats_q.size(), predict_stats(in_now_ns, in_frame_time_ns));
      end
      if (out_valid && !out_stall) begin
        if (stats_q.size() == 0) begin
          note_mismatch("result transfer with no frame outstanding");
        end else begin
          want = stats_q[0];
          stats_q.delete(0);
          if (out_min_frame_ns !== want.min_ns)
            note_mismatch($sformatf("slot %0d min_frame_ns got %0d want %0d",
                                    want.slot, out_min_frame_ns, want.min_ns));
          if (out_max_frame_ns !== want.max_ns)
            note_mismatch($sformatf("slot %0d max_frame_ns got %0d want %0d",
                                    want.slot, out_max_frame_ns, want.max_ns));
          if (out_fps_milli !== want.fps)
            note_mismatch($sformatf("slot %0d fps_milli got %0d want %0d",
                                    want.slot, out_fps_milli, want.fps));
          if (out_fps_updated !== want.updated)
            note_mismatch($sformatf("slot %0d fps_updated got %0b want %0b",
                                    want.slot, out_fps_updated, want.updated));
          if (out_slot_written !== want.slot)
            note_mismatch($sformatf("slot_written got %0d want %0d",
                                    out_slot_written, want.slot));
        end
      end
    end
  end

  task automatic queue_frame(input logic [TS_W-1:0] now, input logic [FT_W-1:0] frame);
    frame_rec_t f;
    f.now_ns = now;
    f.frame_ns = frame;
    frame_q.insert(frame_q.size(), f);
    stamp_ns = now;
  endtask

  // block until every queued frame transferred and every result came back
  task automatic wait_drained();
    do @(posedge clk);
    while (frame_q.size() != 0 || in_valid || stats_q.size() != 0);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] value);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_sampling_period_ns <= value;
    do @(posedge clk);
    while (!cfg_ready);
    period_ns = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly plausible frame streams, some with strides scaled to the period so
  // the rate meter fires often; the rest are arbitrary or backward stamps.
  task automatic queue_random_frames(input int count);
    logic [TS_W-1:0] stride;
    logic [FT_W-1:0] frame;
    logic [TS_W-1:0] now;
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        case ($urandom_range(0, 3))
          0:       stride = TS_W'($urandom_range(0, 2000));
          1:       stride = TS_W'($urandom_range(0, 50_000_000));
          2:       stride = TS_W'(period_ns / $urandom_range(1, 40)) +
                            TS_W'($urandom_range(0, 3));
          default: stride = '0;
        endcase
        now = stamp_ns + stride;
        frame = ($urandom_range(0, 3) == 0) ? FT_W'($urandom) : FT_W'(stride);
      end else if (pick < 90) begin
        now = {32'($urandom), 32'($urandom)};
        frame = FT_W'($urandom);
      end else begin
        now = stamp_ns - TS_W'($urandom_range(1, 1000));
        frame = FT_W'($urandom);
      end
      queue_frame(now, frame);
    end
  endtask

  initial begin : stimulus
    logic [TS_W-1:0] base;
    logic [PERIOD_W-1:0] period_plan [8];
    int ph;
    int k;

    foreach (ring_ns[i]) ring_ns[i] = '0;
    stamp_ns = '0;

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Period 0 before the first frame: zero elapsed time with zero frames
    // counted, then zero elapsed with frames pending (full scale).
    write_period('0);
    queue_frame(64'd0, 32'd0);
    queue_frame(64'd0, 32'hFFFF_FFFF);
    queue_frame(64'd1, 32'd1);
    queue_frame('1, 32'h8000_0000);
    // stamp goes backwards: wrapped elapsed time is huge
    queue_frame(64'h8000_0000_0000_0000, 32'h7FFF_FFFF);
    wait_drained();

    // widest period; exact-threshold update one ns after a near miss
    write_period('1);
    base = 64'h8000_0000_0000_0000 + 64'h3_FFFF_FFFF;
    queue_frame(base - 64'd1, 32'h5555_5555);
    queue_frame(base, 32'hAAAA_AAAA);
    wait_drained();

    // 1 us period: rates near the 32-bit limit, truncation, saturation
    write_period(PERIOD_W'(1000));
    for (k = 1; k <= 4; k++) queue_frame(base + TS_W'(250 * k), FT_W'(k * 1000));
    for (k = 6; k <= 10; k++) queue_frame(base + TS_W'(200 * k), FT_W'(k * 1000));
    queue_frame(base + 64'd2300, 32'd300);
    queue_frame(base + 64'd2600, 32'd300);
    queue_frame(base + 64'd3001, 32'd401);
    for (k = 1; k <= 6; k++) queue_frame(base + 64'd3001 + TS_W'(167 * k), 32'd167);
    wait_drained();

    period_plan[0] = PERIOD_W'(500_000_000);
    period_plan[1] = PERIOD_W'(1000);
    period_plan[2] = '0;
    period_plan[3] = '1;
    period_plan[4] = PERIOD_W'(16_666_667);
    period_plan[5] = PERIOD_W'(250);
    period_plan[6] = {2'($urandom_range(0, 3)), 32'($urandom)};
    period_plan[7] = PERIOD_W'(100_000);

    // Random phases; each starts from an empty pipe so the period write is
    // safe, and the idle/stall mix rotates so gaps land on every stage.
    for (ph = 0; ph < 8; ph++) begin
      wait_drained();
      write_period(period_plan[ph]);
      case (ph % 4)
        0:       begin send_idle_pct = 0;  stall_pct = 0;  end
        1:       begin send_idle_pct = 85; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 35; stall_pct = 35; end
      endcase
      queue_random_frames(135);
    end

    // Back-pressure: hold results off long enough that the block fills and
    // stalls its input while the sender keeps offering.
    wait_drained();
    write_period(PERIOD_W'(2_000_000));
    send_idle_pct = 0;
    stall_pct = 0;
    queue_random_frames(50);
    @(posedge clk);
    hold_left = 3000;
    wait_drained();

    // quiet tail: any stray result transfer here is flagged by the monitor
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("frame_time_window_stats verification clean");
    end else begin
      $display("frame_time_window_stats verification failed");
    end
    $finish;
  end

endmodule
